### rtl/slot_registry_table_unit_defines.svh
// Assertion macros shared by the slot registry table RTL.
`ifndef SLOT_REGISTRY_TABLE_UNIT_DEFINES_SVH
`define SLOT_REGISTRY_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot registry check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot registry check failed");

`endif

### rtl/srt_pkg.sv
// Types, constants and helper functions of the slot registry table.
package srt_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int HW_W       = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] CMD_ALLOC      = 3'd0;
  localparam logic [2:0] CMD_FREE       = 3'd1;
  localparam logic [2:0] CMD_FIND_OWNER = 3'd2;
  localparam logic [2:0] CMD_FIND_TASK  = 3'd3;
  localparam logic [2:0] CMD_FIND_PREV  = 3'd4;
  localparam logic [2:0] CMD_RESET      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [31:0] OWNER_FREE     = 32'h0000_0000;
  localparam logic [31:0] OWNER_SENTINEL = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] owner_handle;
    logic [31:0] task_handle;
    logic        attached;
    logic [5:0]  start_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  hit_slot;
    logic [31:0] hit_owner;
    logic [31:0] hit_task;
    logic [31:0] hit_token;
    logic        hit_attached;
  } out_item_t;

  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] task_handle;
    logic [31:0] token;
    logic        attached;
  } slot_entry_t;

  // Per-slot compare results from the shared match unit.
  typedef struct packed {
    logic is_free;
    logic live;
    logic owner_eq;
    logic task_hit;
    logic token_gt;
    logic prev_hit;
  } match_t;

  // Contents of a slot that has not been written since the last table reset.
  function automatic slot_entry_t slot_reset_value(logic [SLOT_W-1:0] idx);
    slot_entry_t e;
    e = '0;
    if (idx == SLOT_W'(0) || idx == SLOT_W'(2)) begin
      e.owner = OWNER_SENTINEL;
    end
    return e;
  endfunction

endpackage

### rtl/srt_slot_mem.sv
// Slot storage: one write port, one registered read port, per-slot valid bits.
module srt_slot_mem
  import srt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear_all,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  slot_entry_t       wr_data
);

  slot_entry_t             mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   vld_r;
  slot_entry_t             mem_q_r;
  logic                    vld_q_r;
  logic [SLOT_W-1:0]       idx_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      idx_q_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (rd_en) begin
        vld_q_r <= vld_r[rd_addr];
      end
      if (clear_all) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // A slot never written since reset reads as its initial contents.
  assign rd_data = vld_q_r ? mem_q_r : slot_reset_value(idx_q_r);

endmodule

### rtl/srt_match.sv
// Shared compare unit: checks one slot against the command's search keys.
module srt_match
  import srt_pkg::*;
(
  input  slot_entry_t entry,
  input  logic [31:0] key_owner,
  input  logic [31:0] key_task,
  input  logic [31:0] best_token,
  output match_t      m
);

  logic live;

  assign live = (entry.owner != OWNER_FREE) && (entry.owner != OWNER_SENTINEL);

  always_comb begin
    m          = '0;
    m.is_free  = (entry.owner == OWNER_FREE);
    m.live     = live;
    m.owner_eq = (entry.owner == key_owner);
    m.task_hit = live && (entry.task_handle == key_task);
    m.token_gt = (entry.token > best_token);
    m.prev_hit = live && entry.attached;
  end

endmodule

### rtl/slot_registry_table_unit.sv
// Top level of the slot registry table: command decode and slot scan sequencer.
//
// One command is taken at a rising edge where start is high and busy is low;
// its fields come in on in_data. Exactly one result comes back on out_data,
// marked by out_valid for a single cycle; the receiver must take it then.
// Rejected arguments, unknown commands and the reset command answer in the
// cycle after acceptance. Allocate, free and the find commands scan the
// table one slot per cycle through a pipelined read of the slot memory and
// one shared compare unit; a hit ends the scan early, except for find-task,
// which scans its whole range for the highest token. busy stays high for the
// whole scan, so commands are taken one at a time, and drops in the cycle
// that the result is shown. Reset (rst_n low) and the reset command both
// restore the initial table at once through per-slot valid bits: slots 0 and
// 2 hold sentinel owners, everything else is zero, and the high-water mark
// and token counter clear. No clearing pass is needed.
`include "slot_registry_table_unit_defines.svh"

module slot_registry_table_unit
  import srt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [31:0]       key_owner_r, key_owner_nxt;
  logic [31:0]       key_task_r, key_task_nxt;
  logic              key_att_r, key_att_nxt;
  logic              down_r, down_nxt;
  logic              iss_on_r, iss_on_nxt;
  logic [SLOT_W-1:0] iss_idx_r, iss_idx_nxt;
  logic              iss_last_r, iss_last_nxt;
  logic [SLOT_W-1:0] end_idx_r, end_idx_nxt;
  logic              chk_on_r, chk_on_nxt;
  logic [SLOT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic              chk_last_r, chk_last_nxt;
  logic              best_found_r, best_found_nxt;
  logic [SLOT_W-1:0] best_idx_r, best_idx_nxt;
  slot_entry_t       best_r, best_nxt;
  logic [HW_W-1:0]   hw_r, hw_nxt;
  logic [31:0]       token_r, token_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              clear_all;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_entry_t       wr_data;
  slot_entry_t       rd_data;
  match_t            m;

  logic              accept;
  logic [HW_W-1:0]   first_idx;
  logic [HW_W-1:0]   prev_start;
  logic [HW_W-1:0]   slot_p1;
  logic [SLOT_W-1:0] step_idx;
  logic              best_upd;
  slot_entry_t       alloc_entry;

  function automatic out_item_t make_out(logic [1:0] st, logic [SLOT_W-1:0] idx,
                                         slot_entry_t e);
    out_item_t o;
    o = '0;
    o.status = st;
    if (st == ST_OK) begin
      o.hit_slot     = 6'(idx);
      o.hit_owner    = e.owner;
      o.hit_task     = e.task_handle;
      o.hit_token    = e.token;
      o.hit_attached = e.attached;
    end
    return o;
  endfunction

  srt_slot_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_all (clear_all),
    .rd_en     (iss_on_r),
    .rd_addr   (iss_idx_r),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  srt_match u_match (
    .entry      (rd_data),
    .key_owner  (key_owner_r),
    .key_task   (key_task_r),
    .best_token (best_r.token),
    .m          (m)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign first_idx = (hw_r == '0) ? HW_W'(1) : hw_r;
  assign prev_start = (HW_W'(in_data.start_slot) > HW_W'(SLOT_COUNT)) ?
                      HW_W'(SLOT_COUNT) : HW_W'(in_data.start_slot);
  assign slot_p1   = HW_W'(chk_idx_r) + HW_W'(1);
  assign step_idx  = down_r ? (iss_idx_r - SLOT_W'(1)) : (iss_idx_r + SLOT_W'(1));
  assign best_upd  = chk_on_r && (cmd_r == CMD_FIND_TASK) && m.task_hit &&
                     (!best_found_r || m.token_gt);

  always_comb begin
    alloc_entry             = '0;
    alloc_entry.owner       = key_owner_r;
    alloc_entry.task_handle = key_task_r;
    alloc_entry.token       = token_r + 32'd1;
    alloc_entry.attached    = key_att_r;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_owner_nxt  = key_owner_r;
    key_task_nxt   = key_task_r;
    key_att_nxt    = key_att_r;
    down_nxt       = down_r;
    iss_on_nxt     = iss_on_r;
    iss_idx_nxt    = iss_idx_r;
    iss_last_nxt   = iss_last_r;
    end_idx_nxt    = end_idx_r;
    chk_on_nxt     = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    chk_last_nxt   = chk_last_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    hw_nxt         = hw_r;
    token_nxt      = token_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    clear_all      = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = chk_idx_r;
    wr_data        = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_data.command;
          key_owner_nxt  = in_data.owner_handle;
          key_task_nxt   = in_data.task_handle;
          key_att_nxt    = in_data.attached;
          best_found_nxt = 1'b0;
          down_nxt       = 1'b0;
          iss_idx_nxt    = '0;
          end_idx_nxt    = SLOT_W'(hw_r - HW_W'(1));
          unique case (in_data.command) inside
            CMD_ALLOC: begin
              if (in_data.owner_handle == OWNER_FREE) begin
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_INVALID, '0, '0);
              end else if (first_idx >= HW_W'(SLOT_COUNT)) begin
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_FULL, '0, '0);
              end else begin
                state_nxt   = S_SCAN;
                iss_on_nxt  = 1'b1;
                iss_idx_nxt = SLOT_W'(first_idx);
                end_idx_nxt = SLOT_W'(SLOT_COUNT - 1);
              end
            end
            CMD_FREE, CMD_FIND_OWNER: begin
              if (in_data.owner_handle == OWNER_FREE ||
                  in_data.owner_handle == OWNER_SENTINEL || hw_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_NOTFOUND, '0, '0);
              end else begin
                state_nxt  = S_SCAN;
                iss_on_nxt = 1'b1;
              end
            end
            CMD_FIND_TASK: begin
              if (in_data.task_handle == 32'd0 || hw_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_NOTFOUND, '0, '0);
              end else begin
                state_nxt  = S_SCAN;
                iss_on_nxt = 1'b1;
              end
            end
            CMD_FIND_PREV: begin
              if (prev_start == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_NOTFOUND, '0, '0);
              end else begin
                state_nxt   = S_SCAN;
                iss_on_nxt  = 1'b1;
                down_nxt    = 1'b1;
                iss_idx_nxt = SLOT_W'(prev_start - HW_W'(1));
                end_idx_nxt = '0;
              end
            end
            CMD_RESET: begin
              clear_all     = 1'b1;
              hw_nxt        = '0;
              token_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = make_out(ST_OK, '0, '0);
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = make_out(ST_INVALID, '0, '0);
            end
          endcase
          iss_last_nxt = (iss_idx_nxt == end_idx_nxt);
        end
      end

      S_SCAN: begin
        // Read address goes out in the cycle before the compare on its data.
        if (iss_on_r) begin
          chk_on_nxt   = 1'b1;
          chk_idx_nxt  = iss_idx_r;
          chk_last_nxt = iss_last_r;
          if (iss_last_r) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_idx_nxt  = step_idx;
            iss_last_nxt = (step_idx == end_idx_r);
          end
        end

        if (best_upd) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = chk_idx_r;
          best_nxt       = rd_data;
        end

        if (chk_on_r) begin
          unique case (cmd_r) inside
            CMD_ALLOC: begin
              if (m.is_free) begin
                wr_en         = 1'b1;
                wr_data       = alloc_entry;
                token_nxt     = alloc_entry.token;
                if (hw_r < slot_p1) begin
                  hw_nxt = slot_p1;
                end
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_OK, chk_idx_r, alloc_entry);
              end else if (chk_last_r) begin
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_FULL, '0, '0);
              end
            end
            CMD_FREE, CMD_FIND_OWNER: begin
              if (m.owner_eq) begin
                if (cmd_r == CMD_FREE) begin
                  wr_en         = 1'b1;
                  wr_data       = rd_data;
                  wr_data.owner = OWNER_FREE;
                end
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_OK, chk_idx_r, rd_data);
              end else if (chk_last_r) begin
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_NOTFOUND, '0, '0);
              end
            end
            CMD_FIND_TASK: begin
              if (chk_last_r) begin
                out_valid_nxt = 1'b1;
                if (best_upd) begin
                  out_nxt = make_out(ST_OK, chk_idx_r, rd_data);
                end else if (best_found_r) begin
                  out_nxt = make_out(ST_OK, best_idx_r, best_r);
                end else begin
                  out_nxt = make_out(ST_NOTFOUND, '0, '0);
                end
              end
            end
            CMD_FIND_PREV: begin
              if (m.prev_hit) begin
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_OK, chk_idx_r, rd_data);
              end else if (chk_last_r) begin
                out_valid_nxt = 1'b1;
                out_nxt       = make_out(ST_NOTFOUND, '0, '0);
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = make_out(ST_INVALID, '0, '0);
            end
          endcase
        end

        // The result ends the scan; any read already in flight is dropped.
        if (out_valid_nxt) begin
          state_nxt  = S_IDLE;
          iss_on_nxt = 1'b0;
          chk_on_nxt = 1'b0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_on_r    <= 1'b0;
      chk_on_r    <= 1'b0;
      hw_r        <= '0;
      token_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_on_r    <= iss_on_nxt;
      chk_on_r    <= chk_on_nxt;
      hw_r        <= hw_nxt;
      token_r     <= token_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_owner_r  <= key_owner_nxt;
    key_task_r   <= key_task_nxt;
    key_att_r    <= key_att_nxt;
    down_r       <= down_nxt;
    iss_idx_r    <= iss_idx_nxt;
    iss_last_r   <= iss_last_nxt;
    end_idx_r    <= end_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    chk_last_r   <= chk_last_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    out_r        <= out_nxt;
  end

  // An accepted transaction either answers next cycle or keeps the block busy.
  `SRT_ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, busy || out_valid)
  // A result is shown only once the scan has finished.
  `SRT_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid, !busy)
  // Failed commands carry no slot contents.
  `SRT_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.hit_slot == '0 && out_data.hit_owner == '0 && out_data.hit_token == '0)
  // The high-water mark never passes the table size.
  `SRT_ASSERT_NOW(a_hw_bound, clk, rst_n, 1'b1, hw_r <= HW_W'(SLOT_COUNT))

endmodule
